// ----- sv/meam_pkg.sv -----
// Package with shared types, constants and helper functions for the MIDI event action mapper.
package meam_pkg;

	localparam int MaxEntries = 32;
	localparam int IdxW = $clog2(MaxEntries);
	localparam int CntW = $clog2(MaxEntries + 1);
	localparam int WordW = 48;

	// Command codes.
	localparam logic [2:0] CMD_MAP     = 3'd0;
	localparam logic [2:0] CMD_APPEND  = 3'd1;
	localparam logic [2:0] CMD_REPLACE = 3'd2;
	localparam logic [2:0] CMD_ERASE   = 3'd3;
	localparam logic [2:0] CMD_CLEAR   = 3'd4;
	localparam logic [2:0] CMD_RELEASE = 3'd5;

	// Event type codes.
	localparam logic [2:0] EV_NOTEOFF   = 3'd0;
	localparam logic [2:0] EV_NOTEON    = 3'd1;
	localparam logic [2:0] EV_CC        = 3'd3;
	localparam logic [2:0] EV_PROG      = 3'd4;
	localparam logic [2:0] EV_CHANPRESS = 3'd5;
	localparam logic [2:0] EV_BEND      = 3'd6;

	// Trigger kinds.
	localparam logic [2:0] TRIG_PRESS    = 3'd0;
	localparam logic [2:0] TRIG_RELEASE  = 3'd1;
	localparam logic [2:0] TRIG_PRESSREL = 3'd2;
	localparam logic [2:0] TRIG_TOGGLE   = 3'd3;
	localparam logic [2:0] TRIG_VALUE    = 3'd4;
	localparam logic [2:0] TRIG_RELATIVE = 3'd5;

	// Relative encoder modes.
	localparam logic [1:0] REL_TWOS   = 2'd0;
	localparam logic [1:0] REL_OFFSET = 2'd1;

	// Configuration register indexes.
	localparam logic REG_HARM_FIRST = 1'b0;
	localparam logic REG_HARM_LAST  = 1'b1;

	localparam logic [7:0] SourceBase = 8'd128;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERASE,
		ST_SCAN_RD,
		ST_SCAN_EVAL,
		ST_FINAL,
		ST_OUT
	} meam_state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load_item;
		logic do_table;
		logic erase_step;
		logic erase_done;
		logic scan_reset;
		logic scan_read;
		logic scan_eval;
		logic final_load;
		logic out_take;
	} meam_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic is_map;
		logic is_erase_ok;
		logic erase_more;
		logic scan_more;
		logic eval_fire;
		logic erase_busy;
		logic out_full;
	} meam_sts_t;

	// Output item.
	typedef struct packed {
		logic       ok;
		logic       fired;
		logic [6:0] act;
		logic [7:0] val;
		logic       pressed;
		logic [7:0] src;
		logic       consumed;
		logic       last;
	} meam_res_t;

	// Relative encoder decoding.
	function automatic logic [7:0] decode_relative(input logic [6:0] v, input logic [1:0] mode);
		logic [7:0] r;
		begin
			if (mode == REL_TWOS) r = {v[6], v};
			else if (mode == REL_OFFSET) r = {1'b0, v} - 8'd64;
			else if (v[5:0] == 6'd0) r = 8'd0;
			else if (v[6]) r = 8'd0 - {2'b00, v[5:0]};
			else r = {2'b00, v[5:0]};
			return r;
		end
	endfunction

endpackage

// ----- sv/meam_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
module meam_ram #(
	parameter int Width = 8,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ----- sv/meam_ctrl.sv -----
// Controller state machine sequencing table commands, scans and result transfers.
module meam_ctrl import meam_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  meam_sts_t   sts,
	output meam_cmd_t   cmd
);
	meam_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = !sts.out_full;
				if (in_valid && !sts.out_full) begin
					cmd.load_item = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// Item registered; dispatch on its command.
				if (sts.is_map) begin
					cmd.scan_reset = 1'b1;
					state_d = ST_SCAN_RD;
				end else if (sts.is_erase_ok) begin
					state_d = ST_ERASE;
				end else begin
					cmd.do_table = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_ERASE: begin
				// Each shift needs its read cycle and then its write cycle.
				if (!sts.erase_busy) begin
					if (sts.erase_more) cmd.erase_step = 1'b1;
					else begin
						cmd.erase_done = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_SCAN_RD: begin
				if (sts.scan_more) begin
					cmd.scan_read = 1'b1;
					state_d = ST_SCAN_EVAL;
				end else state_d = ST_FINAL;
			end
			ST_SCAN_EVAL: begin
				// A firing entry waits until the output register is free.
				if (!(sts.eval_fire && sts.out_full)) begin
					cmd.scan_eval = 1'b1;
					state_d = ST_SCAN_RD;
				end
			end
			ST_FINAL: begin
				if (!sts.out_full) begin
					cmd.final_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ----- sv/meam_dp.sv -----
// Datapath: entry table, mark bits, entry match logic and result registers.
module meam_dp import meam_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [2:0]   in_command,
	input  logic [4:0]   in_index,
	input  logic [47:0]  in_word,
	input  logic [2:0]   in_etype,
	input  logic [3:0]   in_chan,
	input  logic [3:0]   in_cable,
	input  logic [6:0]   in_d1,
	input  logic [6:0]   in_d2,
	input  logic [13:0]  in_bend,
	input  logic         cfg_we,
	input  logic         cfg_idx,
	input  logic [6:0]   cfg_data,
	input  meam_cmd_t    cmd,
	output meam_sts_t    sts,
	input  logic         out_ready,
	output logic         out_valid,
	output meam_res_t    out_res
);
	logic [2:0]          cmd_q;
	logic [IdxW-1:0]     idx_q;
	logic [WordW-1:0]    word_q;
	logic [2:0]          et_q;
	logic [3:0]          ch_q, cb_q;
	logic [6:0]          d1_q, d2_q, evval_q;
	logic [6:0]          hfirst_q, hlast_q;
	logic [CntW-1:0]     count_q;
	logic [MaxEntries-1:0] held_q, tog_q;
	logic [CntW-1:0]     ptr_q;
	logic [IdxW-1:0]     eval_idx_q;
	logic                cons_q, fired_q;
	logic                out_valid_q;
	meam_res_t           res_q;
	meam_res_t           pend_q;

	// RAM port signals.
	logic                ram_we;
	logic [IdxW-1:0]     ram_waddr, ram_raddr;
	logic [WordW-1:0]    ram_wdata, ram_rdata;

	logic is_press, is_release;
	logic [6:0] evval;

	// Event classification of the registered item.
	assign is_press = (et_q == EV_NOTEON) || (et_q == EV_CC && d2_q != 7'd0) || (et_q == EV_PROG);
	assign is_release = (et_q == EV_NOTEOFF) || (et_q == EV_CC && d2_q == 7'd0);

	always_comb begin
		if (in_etype == EV_BEND) evval = in_bend[13:7];
		else if (in_etype == EV_PROG || in_etype == EV_CHANPRESS) evval = in_d1;
		else evval = in_d2;
	end

	// Entry fields of the word read from the table.
	logic [2:0] e_type, e_trig;
	logic [1:0] e_rel;
	logic [6:0] e_act, e_min, e_max;
	logic match, held_i, tog_i, pressed, released, fire, apr, tog_new;
	logic [7:0] val;

	always_comb begin
		e_type = ram_rdata[2:0];
		e_min = ram_rdata[27:21];
		e_max = ram_rdata[34:28];
		e_trig = ram_rdata[37:35];
		e_rel = ram_rdata[39:38];
		e_act = ram_rdata[46:40];
		held_i = held_q[eval_idx_q];
		tog_i = tog_q[eval_idx_q];
		match = (e_type == et_q || (e_type == EV_NOTEON && et_q == EV_NOTEOFF))
			&& (ram_rdata[7] || ram_rdata[6:3] == ch_q)
			&& (ram_rdata[12] || ram_rdata[11:8] == cb_q)
			&& (ram_rdata[20] || ram_rdata[19:13] == d1_q)
			&& (is_release || (evval_q >= e_min && evval_q <= e_max));
		pressed = is_press && (!held_i || et_q == EV_PROG);
		released = is_release && held_i;
		fire = 1'b0;
		apr = 1'b1;
		val = {1'b0, evval_q};
		tog_new = tog_i;
		case (e_trig)
			TRIG_PRESS: fire = pressed;
			TRIG_RELEASE: fire = released;
			TRIG_PRESSREL: begin
				fire = pressed || released;
				val = {7'd0, pressed};
				apr = pressed;
			end
			TRIG_TOGGLE: begin
				if (pressed) begin
					tog_new = !tog_i;
					val = {7'd0, tog_new};
					fire = 1'b1;
					if (e_act >= hfirst_q && e_act <= hlast_q) apr = tog_new;
				end
			end
			TRIG_VALUE: fire = 1'b1;
			TRIG_RELATIVE: begin
				val = decode_relative(evval_q, e_rel);
				fire = val != 8'd0;
			end
			default: fire = 1'b0;
		endcase
		fire = fire && match;
	end

	// Erase shift: read entry ptr, write it one place lower. The read address stays on
	// the entry under evaluation so a stalled evaluation keeps its data.
	logic erase_wr_q;
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = word_q;
		ram_raddr = (cmd.scan_read || cmd.erase_step) ? ptr_q[IdxW-1:0] : eval_idx_q;
		if (cmd.do_table && cmd_q == CMD_APPEND && count_q < CntW'(MaxEntries)) begin
			ram_we = 1'b1;
			ram_waddr = count_q[IdxW-1:0];
		end else if (cmd.do_table && cmd_q == CMD_REPLACE && {1'b0, idx_q} < count_q
			&& word_q[46:40] != 7'd0) begin
			ram_we = 1'b1;
		end else if (erase_wr_q) begin
			ram_we = 1'b1;
			ram_waddr = eval_idx_q;
			ram_wdata = ram_rdata;
		end
	end

	meam_ram #(.Width(WordW), .Depth(MaxEntries)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Item registers (payload).
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cmd_q <= in_command;
			idx_q <= in_index[IdxW-1:0];
			word_q <= in_word;
			et_q <= in_etype;
			ch_q <= in_chan;
			cb_q <= in_cable;
			d1_q <= in_d1;
			d2_q <= in_d2;
			evval_q <= evval;
		end
	end

	logic table_ok;
	always_comb begin
		case (cmd_q)
			CMD_APPEND: table_ok = count_q < CntW'(MaxEntries);
			CMD_REPLACE: table_ok = {1'b0, idx_q} < count_q && word_q[46:40] != 7'd0;
			CMD_ERASE: table_ok = {1'b0, idx_q} < count_q;
			CMD_CLEAR, CMD_RELEASE: table_ok = 1'b1;
			default: table_ok = 1'b0;
		endcase
	end

	// Control state: table count, marks, scan pointer, result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hfirst_q <= 7'd3;
			hlast_q <= 7'd10;
			count_q <= '0;
			held_q <= '0;
			tog_q <= '0;
			ptr_q <= '0;
			eval_idx_q <= '0;
			cons_q <= 1'b0;
			fired_q <= 1'b0;
			erase_wr_q <= 1'b0;
			out_valid_q <= 1'b0;
			res_q <= '0;
			pend_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_HARM_FIRST) hfirst_q <= cfg_data;
				else hlast_q <= cfg_data;
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			erase_wr_q <= 1'b0;
			if (cmd.load_item) begin
				ptr_q <= CntW'(in_index[IdxW-1:0]) + CntW'(1);
				eval_idx_q <= in_index[IdxW-1:0];
			end
			if (cmd.do_table) begin
				case (cmd_q)
					CMD_APPEND: if (table_ok) begin
						held_q[count_q[IdxW-1:0]] <= 1'b0;
						tog_q[count_q[IdxW-1:0]] <= 1'b0;
						count_q <= count_q + CntW'(1);
					end
					CMD_REPLACE: if (table_ok) begin
						held_q[idx_q] <= 1'b0;
						tog_q[idx_q] <= 1'b0;
					end
					CMD_CLEAR: count_q <= '0;
					CMD_RELEASE: held_q <= '0;
					default: ;
				endcase
				out_valid_q <= 1'b1;
				res_q <= '{ok: table_ok, last: 1'b1, default: '0};
			end
			// One erase step: entry ptr moves to ptr-1, written in the cycle after its read.
			if (cmd.erase_step) begin
				held_q[eval_idx_q] <= held_q[ptr_q[IdxW-1:0]];
				tog_q[eval_idx_q] <= tog_q[ptr_q[IdxW-1:0]];
				erase_wr_q <= 1'b1;
			end
			if (erase_wr_q) begin
				eval_idx_q <= eval_idx_q + IdxW'(1);
				ptr_q <= ptr_q + CntW'(1);
			end
			if (cmd.erase_done) begin
				count_q <= count_q - CntW'(1);
				out_valid_q <= 1'b1;
				res_q <= '{ok: 1'b1, last: 1'b1, default: '0};
			end
			if (cmd.scan_reset) begin
				ptr_q <= '0;
				cons_q <= 1'b0;
				fired_q <= 1'b0;
			end
			if (cmd.scan_read) begin
				eval_idx_q <= ptr_q[IdxW-1:0];
				ptr_q <= ptr_q + CntW'(1);
			end
			if (cmd.scan_eval && match) begin
				if (is_press) held_q[eval_idx_q] <= 1'b1;
				if (released) held_q[eval_idx_q] <= 1'b0;
				tog_q[eval_idx_q] <= tog_new;
				if (ram_rdata[47]) cons_q <= 1'b1;
				// A fired result is held back one step so the last one can be marked.
				if (fire) begin
					fired_q <= 1'b1;
					if (fired_q) begin
						out_valid_q <= 1'b1;
						res_q <= pend_q;
					end
					pend_q <= '{ok: 1'b1, fired: 1'b1, act: e_act, val: val, pressed: apr,
						src: SourceBase + 8'(eval_idx_q), default: '0};
				end
			end
			if (cmd.final_load) begin
				out_valid_q <= 1'b1;
				if (fired_q) res_q <= '{ok: 1'b1, fired: 1'b1, act: pend_q.act,
					val: pend_q.val, pressed: pend_q.pressed, src: pend_q.src,
					consumed: cons_q, last: 1'b1};
				else res_q <= '{ok: 1'b1, consumed: cons_q, last: 1'b1, default: '0};
			end
		end
	end

	// The pending fired result sits in pend_q until the next fire or the end of the scan.
	assign out_valid = out_valid_q;
	assign out_res = res_q;

	always_comb begin
		sts.is_map = cmd_q == CMD_MAP;
		sts.is_erase_ok = cmd_q == CMD_ERASE && table_ok;
		sts.erase_more = ptr_q < count_q;
		sts.scan_more = ptr_q < count_q;
		sts.eval_fire = fire;
		sts.erase_busy = erase_wr_q;
		sts.out_full = out_valid_q;
	end
endmodule

// ----- sv/midi_event_action_mapper.sv -----
// Top level of the MIDI event action mapper.
// Each command takes one transfer on s_axis and gives its results on m_axis. Table
// commands give one result; erase shifts each later entry one place down. A map
// command walks the table through the entry RAM's registered read port, reading and
// then evaluating each entry; a firing entry waits while the result register is untaken.
// The table holds 32 entries; configuration writes on cfg are taken in every cycle and
// should only be issued while no item is in flight.
module midi_event_action_mapper import meam_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// command[2:0], entry_index[7:3], entry_word[55:8], event_type[58:56],
	// event_channel[62:59], event_cable[66:63], event_data1[73:67],
	// event_data2[80:74], event_bend[94:81], zero fill [95]
	input  logic [95:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// ok[0], fired[1], action_code[8:2], action_value[16:9], action_pressed[17],
	// source_id[25:18], consumed[26], zero fill [31:27]
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);
	meam_cmd_t cmd;
	meam_sts_t sts;
	meam_res_t res;

	assign cfg_ready = 1'b1;

	meam_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	meam_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_command (s_axis_tdata[2:0]),
		.in_index   (s_axis_tdata[7:3]),
		.in_word    (s_axis_tdata[55:8]),
		.in_etype   (s_axis_tdata[58:56]),
		.in_chan    (s_axis_tdata[62:59]),
		.in_cable   (s_axis_tdata[66:63]),
		.in_d1      (s_axis_tdata[73:67]),
		.in_d2      (s_axis_tdata[80:74]),
		.in_bend    (s_axis_tdata[94:81]),
		.cfg_we     (cfg_valid),
		.cfg_idx    (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_res    (res)
	);

	// Result packing.
	assign m_axis_tdata = {5'd0, res.consumed, res.src, res.pressed, res.val, res.act,
		res.fired, res.ok};
	assign m_axis_tlast = res.last;

`ifndef ASSERT_OFF
	// No new item is taken while a result waits.
	a_no_accept_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("item taken over pending result");
	// A fired result always reports ok.
	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res.fired) |-> res.ok) else $error("fired without ok");
	// Consumed appears only on a last result.
	a_cons_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res.consumed) |-> res.last) else $error("consumed not last");
`endif
endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the MIDI event action mapper.
module tb;
	import meam_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [6:0]  cfg_data = '0;

	midi_event_action_mapper u_top (.*);

	always #2 clk = ~clk;

	// One command or event as it travels on the slave stream.
	typedef struct {
		logic [2:0]  cmd;
		logic [4:0]  idx;
		logic [47:0] word;
		logic [2:0]  et;
		logic [3:0]  ch;
		logic [3:0]  cb;
		logic [6:0]  d1;
		logic [6:0]  d2;
		logic [13:0] bend;
	} midi_cmd_t;

	// Mirror of the block's table and marks.
	logic [47:0] table_words[MaxEntries];
	logic        held[MaxEntries];
	logic        tog[MaxEntries];
	int          n_entries;
	logic [6:0]  harm_lo, harm_hi;

	meam_res_t expected_q[$];
	int  errors = 0;
	int  results_seen = 0;
	int  fired_seen = 0;
	logic quiet = 1'b0;

	function automatic logic [7:0] rel_step(logic [6:0] v, logic [1:0] mode);
		if (mode == REL_TWOS) return {v[6], v};
		if (mode == REL_OFFSET) return 8'(int'(v) - 64);
		if (v[5:0] == 0) return 8'd0;
		return v[6] ? 8'(-int'(v[5:0])) : 8'({2'b00, v[5:0]});
	endfunction

	function automatic meam_res_t mk_res(logic ok, logic fired, logic [6:0] act,
			logic [7:0] val, logic pr, logic [7:0] src, logic cons, logic last);
		meam_res_t r;
		r.ok = ok; r.fired = fired; r.act = act; r.val = val; r.pressed = pr;
		r.src = src; r.consumed = cons; r.last = last;
		return r;
	endfunction

	// Queue one expected result behind the others.
	function automatic void add_expect(meam_res_t r);
		expected_q.insert(expected_q.size(), r);
	endfunction

	// Predict the results of one command and update the mirror.
	task automatic predict_mapping(midi_cmd_t c);
		logic ok, is_press, is_release, cons, pressed, released, fire, apr;
		logic [6:0] evval, act;
		logic [7:0] val;
		logic [47:0] w;
		logic [2:0] st, trig;
		int n;
		ok = 1'b0; cons = 1'b0; n = 0;
		if (c.cmd != CMD_MAP) begin
			case (c.cmd)
				CMD_APPEND: if (n_entries < MaxEntries) begin
					table_words[n_entries] = c.word;
					held[n_entries] = 0; tog[n_entries] = 0;
					n_entries++; ok = 1;
				end
				CMD_REPLACE: if (c.idx < n_entries && c.word[46:40] != 0) begin
					table_words[c.idx] = c.word;
					held[c.idx] = 0; tog[c.idx] = 0; ok = 1;
				end
				CMD_ERASE: if (c.idx < n_entries) begin
					for (int i = c.idx; i + 1 < n_entries; i++) begin
						table_words[i] = table_words[i+1];
						held[i] = held[i+1]; tog[i] = tog[i+1];
					end
					n_entries--; ok = 1;
				end
				CMD_CLEAR: begin
					n_entries = 0; ok = 1;
				end
				CMD_RELEASE: begin
					foreach (held[i]) held[i] = 0;
					ok = 1;
				end
				default: ok = 0;
			endcase
			add_expect(mk_res(ok, 0, 0, 0, 0, 0, 0, 1));
			return;
		end
		is_press = c.et == EV_NOTEON || (c.et == EV_CC && c.d2 != 0) || c.et == EV_PROG;
		is_release = c.et == EV_NOTEOFF || (c.et == EV_CC && c.d2 == 0);
		if (c.et == EV_BEND) evval = c.bend[13:7];
		else if (c.et == EV_PROG || c.et == EV_CHANPRESS) evval = c.d1;
		else evval = c.d2;
		for (int i = 0; i < n_entries; i++) begin
			w = table_words[i];
			st = w[2:0]; trig = w[37:35]; act = w[46:40];
			if (st != c.et && !(st == EV_NOTEON && c.et == EV_NOTEOFF)) continue;
			if (!w[7] && w[6:3] != c.ch) continue;
			if (!w[12] && w[11:8] != c.cb) continue;
			if (!w[20] && w[19:13] != c.d1) continue;
			if (!is_release && (evval < w[27:21] || evval > w[34:28])) continue;
			pressed = is_press && (!held[i] || c.et == EV_PROG);
			released = is_release && held[i];
			if (is_press) held[i] = 1;
			if (released) held[i] = 0;
			fire = 0; apr = 1; val = {1'b0, evval};
			case (trig)
				TRIG_PRESS: fire = pressed;
				TRIG_RELEASE: fire = released;
				TRIG_PRESSREL: begin
					fire = pressed || released;
					val = pressed ? 8'd1 : 8'd0;
					apr = pressed;
				end
				TRIG_TOGGLE: if (pressed) begin
					tog[i] = ~tog[i];
					val = tog[i] ? 8'd1 : 8'd0;
					fire = 1;
					if (act >= harm_lo && act <= harm_hi) apr = tog[i];
				end
				TRIG_VALUE: fire = 1;
				TRIG_RELATIVE: begin
					val = rel_step(evval, w[39:38]);
					fire = val != 0;
				end
				default: fire = 0;
			endcase
			if (fire) begin
				add_expect(mk_res(1, 1, act, val, apr, SourceBase + 8'(i), 0, 0));
				n++;
			end
			if (w[47]) cons = 1;
		end
		if (n == 0) add_expect(mk_res(1, 0, 0, 0, 0, 0, cons, 1));
		else begin
			expected_q[$].consumed = cons;
			expected_q[$].last = 1;
		end
	endtask

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin
		meam_res_t got, exp_r;
		if (m_axis_tvalid && m_axis_tready) begin
			got = mk_res(m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[8:2],
				m_axis_tdata[16:9], m_axis_tdata[17], m_axis_tdata[25:18],
				m_axis_tdata[26], m_axis_tlast);
			results_seen++;
			if (got.fired) fired_seen++;
			if (expected_q.size() == 0) begin
				$error("unexpected result %h", m_axis_tdata);
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				if (got.ok != exp_r.ok) begin
					$error("ok exp %0d got %0d", exp_r.ok, got.ok); errors++;
				end
				if (got.fired != exp_r.fired) begin
					$error("fired exp %0d got %0d", exp_r.fired, got.fired); errors++;
				end
				if (got.act != exp_r.act) begin
					$error("action_code exp %0d got %0d", exp_r.act, got.act); errors++;
				end
				if (got.val != exp_r.val) begin
					$error("action_value exp %0d got %0d", $signed(exp_r.val),
						$signed(got.val));
					errors++;
				end
				if (got.pressed != exp_r.pressed) begin
					$error("action_pressed exp %0d got %0d", exp_r.pressed, got.pressed);
					errors++;
				end
				if (got.src != exp_r.src) begin
					$error("source_id exp %0d got %0d", exp_r.src, got.src); errors++;
				end
				if (got.consumed != exp_r.consumed) begin
					$error("consumed exp %0d got %0d", exp_r.consumed, got.consumed);
					errors++;
				end
				if (got.last != exp_r.last) begin
					$error("last exp %0d got %0d", exp_r.last, got.last); errors++;
				end
			end
		end
	end

	// Receiver stalls in random bursts.
	always @(posedge clk) begin
		int gap;
		if (quiet) m_axis_tready <= 1'b1;
		else if ($urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			m_axis_tready <= 1'b0;
			repeat (gap) @(posedge clk);
			m_axis_tready <= 1'b1;
		end else m_axis_tready <= 1'b1;
	end

	// Send one item, with an optional random gap beforehand. Valid stays high after the
	// transfer; the next item, a gap or the drain replaces it in the same time step.
	task automatic send_item(midi_cmd_t c);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, c.bend, c.d2, c.d1, c.cb, c.ch, c.et, c.word, c.idx, c.cmd};
		@(negedge clk);
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
		predict_mapping(c);
	endtask

	task automatic write_reg(logic index, logic [6:0] value);
		cfg_valid <= 1'b1; cfg_index <= index; cfg_data <= value;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		if (index == REG_HARM_FIRST) harm_lo = value; else harm_hi = value;
		@(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// Entry word with mostly matchable fields so that scans reach the triggers.
	function automatic logic [47:0] rand_entry();
		logic [47:0] w;
		w = 48'({$urandom, $urandom});
		w[2:0] = $urandom_range(0, 3) == 0 ? 3'($urandom) : 3'($urandom_range(1, 6));
		w[7] = $urandom_range(0, 3) != 0;
		w[12] = $urandom_range(0, 3) != 0;
		w[20] = $urandom_range(0, 2) != 0;
		w[6:3] = 4'($urandom_range(0, 3));
		w[11:8] = 4'($urandom_range(0, 3));
		w[19:13] = 7'($urandom_range(60, 63));
		if ($urandom_range(0, 2) != 0) begin
			w[27:21] = 7'($urandom_range(0, 20));
			w[34:28] = 7'($urandom_range(100, 127));
		end
		w[37:35] = $urandom_range(0, 9) == 0 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
		w[46:40] = $urandom_range(0, 15) == 0 ? 7'($urandom) : 7'($urandom_range(0, 12));
		return w;
	endfunction

	function automatic midi_cmd_t rand_event();
		midi_cmd_t c;
		c.cmd = CMD_MAP; c.idx = 5'($urandom); c.word = 48'({$urandom, $urandom});
		c.et = 3'($urandom_range(0, 7));
		c.ch = $urandom_range(0, 9) == 0 ? 4'($urandom) : 4'($urandom_range(0, 3));
		c.cb = $urandom_range(0, 9) == 0 ? 4'($urandom) : 4'($urandom_range(0, 3));
		c.d1 = $urandom_range(0, 4) == 0 ? 7'($urandom) : 7'($urandom_range(60, 63));
		c.d2 = $urandom_range(0, 5) == 0 ? 7'd0 : 7'($urandom);
		c.bend = 14'($urandom);
		return c;
	endfunction

	// Directed stimulus: commands with fixed expected outcome on row columns.
	typedef struct {
		logic [2:0]  cmd;
		logic [4:0]  idx;
		logic [47:0] word;
		logic [2:0]  et;
		logic [6:0]  d1;
		logic [6:0]  d2;
	} row_t;

	localparam logic [47:0] W_NOTE_TOG  = 48'h05_18_7e_00_10_81;
	localparam logic [47:0] W_NOTE_PR   = 48'h86_10_7e_00_10_81;
	localparam logic [47:0] W_CC_REL2   = 48'h0a_a8_7f_e0_10_83;
	localparam logic [47:0] W_CC_REL1   = 48'h0b_68_7f_e0_10_83;
	localparam logic [47:0] W_PROG_VAL  = 48'h0c_27_f0_00_10_84;
	localparam logic [47:0] W_BEND_VAL  = 48'h0d_27_f0_00_10_86;
	localparam logic [47:0] W_CC_REL0   = 48'h0e_28_7f_e0_10_83;
	localparam logic [47:0] W_NOTE_REL  = 48'h0f_08_7e_00_10_81;
	localparam logic [47:0] W_DEAD_TRIG = 48'h90_38_7e_00_10_81;

	row_t rows[] = '{
		'{CMD_MAP, 0, 0, EV_NOTEON, 7'd60, 7'd100},
		'{CMD_ERASE, 0, 0, 0, 0, 0},
		'{CMD_REPLACE, 0, W_NOTE_PR, 0, 0, 0},
		'{3'd6, 0, 0, 0, 0, 0},
		'{3'd7, 5'd31, '1, 3'd7, 7'd127, 7'd127},
		'{CMD_APPEND, 0, W_NOTE_TOG, 0, 0, 0},
		'{CMD_APPEND, 0, W_NOTE_PR, 0, 0, 0},
		'{CMD_APPEND, 0, W_NOTE_REL, 0, 0, 0},
		'{CMD_APPEND, 0, W_DEAD_TRIG, 0, 0, 0},
		'{CMD_APPEND, 0, W_CC_REL0, 0, 0, 0},
		'{CMD_APPEND, 0, W_CC_REL1, 0, 0, 0},
		'{CMD_APPEND, 0, W_CC_REL2, 0, 0, 0},
		'{CMD_APPEND, 0, W_PROG_VAL, 0, 0, 0},
		'{CMD_APPEND, 0, W_BEND_VAL, 0, 0, 0},
		'{CMD_MAP, 0, 0, EV_NOTEON, 7'd60, 7'd127},
		'{CMD_MAP, 0, 0, EV_NOTEON, 7'd60, 7'd1},
		'{CMD_MAP, 0, 0, EV_NOTEOFF, 7'd60, 7'd0},
		'{CMD_MAP, 0, 0, EV_CC, 7'd127, 7'd65},
		'{CMD_MAP, 0, 0, EV_CC, 7'd127, 7'd0},
		'{CMD_MAP, 0, 0, EV_PROG, 7'd127, 7'd0},
		'{CMD_REPLACE, 5'd1, 48'h0, 0, 0, 0},
		'{CMD_REPLACE, 5'd31, W_NOTE_PR, 0, 0, 0},
		'{CMD_ERASE, 5'd31, 0, 0, 0, 0},
		'{CMD_RELEASE, 0, 0, 0, 0, 0},
		'{CMD_ERASE, 5'd2, 0, 0, 0, 0}
	};
	// Fixed ok column for the rows where it is plain; 2 means use the predictor.
	int row_ok[] = '{2, 0, 0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1,
		2, 2, 2, 2, 2, 2, 0, 0, 0, 1, 1};

	initial begin
		midi_cmd_t c;
		int phase;
		foreach (held[i]) begin
			held[i] = 0; tog[i] = 0; table_words[i] = '0;
		end
		n_entries = 0; harm_lo = 3; harm_hi = 10;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[r]) begin
			c.cmd = rows[r].cmd; c.idx = rows[r].idx; c.word = rows[r].word;
			c.et = rows[r].et; c.ch = 0; c.cb = 0; c.d1 = rows[r].d1; c.d2 = rows[r].d2;
			c.bend = 14'h3fff;
			send_item(c);
			if (row_ok[r] != 2 && expected_q[$].ok != row_ok[r][0]) begin
				$error("ok exp %0d got %0d in table row %0d", row_ok[r],
					expected_q[$].ok, r);
				errors++;
			end
		end
		drain();

		// Random phases under several harmonic ranges, extremes included.
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin write_reg(REG_HARM_FIRST, 0); write_reg(REG_HARM_LAST, 127); end
				1: begin write_reg(REG_HARM_FIRST, 12); write_reg(REG_HARM_LAST, 2); end
				2: begin write_reg(REG_HARM_FIRST, 127); write_reg(REG_HARM_LAST, 127); end
				3: begin
					write_reg(REG_HARM_FIRST, 7'($urandom));
					write_reg(REG_HARM_LAST, 7'($urandom));
				end
				default: begin
					write_reg(REG_HARM_FIRST, 3); write_reg(REG_HARM_LAST, 10);
					quiet = 1'b1;
				end
			endcase
			repeat (44) begin
				int pick;
				pick = $urandom_range(0, 99);
				if (n_entries < 4 || pick < 14) begin
					c = rand_event(); c.cmd = CMD_APPEND; c.word = rand_entry();
					if ($urandom_range(0, 19) == 0) c.word = 48'({$urandom, $urandom});
				end else if (pick < 20) begin
					c = rand_event(); c.cmd = CMD_REPLACE; c.word = rand_entry();
					c.idx = $urandom_range(0, 3) == 0 ? 5'($urandom) : 5'($urandom_range(0, n_entries - 1));
				end else if (pick < 25) begin
					c = rand_event(); c.cmd = CMD_ERASE;
					c.idx = $urandom_range(0, 2) == 0 ? 5'($urandom) : 5'($urandom_range(0, n_entries - 1));
				end else if (pick < 27) begin
					c = rand_event(); c.cmd = $urandom_range(0, 1) ? CMD_CLEAR : 3'($urandom_range(6, 7));
				end else if (pick < 30) begin
					c = rand_event(); c.cmd = CMD_RELEASE;
				end else c = rand_event();
				send_item(c);
			end
			// Fill the table to its limit once, then one more append is refused.
			if (phase == 1) begin
				while (n_entries < MaxEntries) begin
					c = rand_event(); c.cmd = CMD_APPEND; c.word = rand_entry();
					send_item(c);
				end
				c = rand_event(); c.cmd = CMD_APPEND; c.word = rand_entry();
				send_item(c);
				repeat (4) send_item(rand_event());
			end
			drain();
		end

		$display("Covered table commands, mapping events and all harmonic ranges;");
		$display("%0d results checked, %0d of them fired actions.", results_seen, fired_seen);
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
